// ===== design/grmc_pkg.sv =====
package grmc_pkg;

	// Default map side, in cells
	localparam int MAP_DIM = 32;

	// Field widths
	localparam int ROW_W   = 5;
	localparam int COL_W   = 12;
	localparam int DIR_W   = 16;
	localparam int POS_W   = 16;
	localparam int STEP_W  = 8;
	localparam int MAXD_W  = 13;
	localparam int BIAS_W  = 8;
	localparam int SCR_W   = 12;
	localparam int MSZ_W   = 6;
	localparam int DIST_W  = 14;
	localparam int SHADE_W = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_BIAS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 3'd7;

	// Register reset values
	localparam logic [POS_W-1:0]  RST_PLAYER_X      = 16'd768;
	localparam logic [POS_W-1:0]  RST_PLAYER_Y      = 16'd768;
	localparam logic [STEP_W-1:0] RST_STEP_SIZE     = 8'd26;
	localparam logic [MAXD_W-1:0] RST_MAX_DISTANCE  = 13'd4096;
	localparam logic [BIAS_W-1:0] RST_NEAR_BIAS     = 8'd26;
	localparam logic [SCR_W-1:0]  RST_SCREEN_HEIGHT = 12'd1000;
	localparam logic [MSZ_W-1:0]  RST_MAP_WIDTH     = 6'd24;
	localparam logic [MSZ_W-1:0]  RST_MAP_HEIGHT    = 6'd24;

	// Item actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST  = 1'b1;

	// Slice height divider: (screen_height * 256) / (distance + bias)
	localparam int DIV_NUM_W = SCR_W + 8;
	localparam int DIV_DEN_W = DIST_W + 1;

	// Shade: 255.0 - 15 * distance, in Q8.8
	localparam int SHADE_FULL = 255 * 256;

endpackage

// ===== design/grmc_req_if.sv =====
interface grmc_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 action;
	logic        [grmc_pkg::ROW_W-1:0]    cell_row;
	logic        [grmc_pkg::ROW_W-1:0]    cell_col;
	logic                                 cell_wall;
	logic        [grmc_pkg::COL_W-1:0]    column;
	logic signed [grmc_pkg::DIR_W-1:0]    ray_dx;
	logic signed [grmc_pkg::DIR_W-1:0]    ray_dy;

	modport source (
		output valid, action, cell_row, cell_col, cell_wall, column, ray_dx, ray_dy,
		input  ready
	);
	modport sink (
		input  valid, action, cell_row, cell_col, cell_wall, column, ray_dx, ray_dy,
		output ready
	);
endinterface

// ===== design/grmc_rsp_if.sv =====
interface grmc_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [grmc_pkg::COL_W-1:0]      out_column;
	logic [grmc_pkg::DIST_W-1:0]     hit_distance;
	logic                            wall_hit;
	logic [grmc_pkg::SCR_W-1:0]      slice_top;
	logic [grmc_pkg::SCR_W-1:0]      slice_bottom;
	logic [grmc_pkg::SHADE_W-1:0]    shade;

	modport source (
		output valid, out_column, hit_distance, wall_hit, slice_top, slice_bottom, shade,
		input  ready
	);
	modport sink (
		input  valid, out_column, hit_distance, wall_hit, slice_top, slice_bottom, shade,
		output ready
	);
endinterface

// ===== design/grmc_map.sv =====
// One-bit wall map: one write port, one registered read port, clearing pass after reset
module grmc_map #(
	parameter int MAP_DIM = grmc_pkg::MAP_DIM
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [$clog2(MAP_DIM*MAP_DIM)-1:0]     wr_addr,
	input  logic                                   wr_data,
	input  logic                                   rd_en,
	input  logic [$clog2(MAP_DIM*MAP_DIM)-1:0]     rd_addr,
	output logic                                   rd_data,
	output logic                                   clearing
);

	localparam int DEPTH = MAP_DIM * MAP_DIM;
	localparam int AW    = $clog2(DEPTH);

	logic          mem_q [DEPTH];
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;
	logic          rd_data_q;

	// Clear sweep, one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem_q[clr_cnt_q] <= 1'b0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clr_q;

endmodule

// ===== design/grmc_div.sv =====
// Restoring divider, one quotient bit per cycle
module grmc_div #(
	parameter int NUM_W = grmc_pkg::DIV_NUM_W,
	parameter int DEN_W = grmc_pkg::DIV_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	localparam int CW = $clog2(NUM_W);

	logic             busy_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;
	logic             ge;

	// Trial subtract
	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		ge     = !diff[DEN_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== design/grid_ray_march_column_core.sv =====
// Map write: no result; the next item can be taken on the following cycle.
// Cast: each march step checks the point (CHECK) and reads its cell (READ); the march ends
// at a wall, off the map or at the range limit, then the slice height is divided (DIVGO, DIVW).
// One cast in flight; the next item is taken the cycle after the result is loaded, which
// waits while the output register still holds an untaken result.
// Reset: asynchronous, active low; configuration registers take defaults, map cleared after reset.
module grid_ray_march_column_core #(
	parameter int MAP_DIM = grmc_pkg::MAP_DIM
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [grmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [grmc_pkg::CFG_DATA_W-1:0]     cfg_data,
	grmc_req_if.sink                            req,
	grmc_rsp_if.source                          rsp
);

	localparam int AW = $clog2(MAP_DIM * MAP_DIM);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_DIVGO = 3'd3;
	localparam logic [2:0] ST_DIVW  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	typedef struct packed {
		logic       neg_out;
		logic [8:0] idx;
	} cell_t;

	// Configuration registers
	logic [grmc_pkg::POS_W-1:0]  player_x_q;
	logic [grmc_pkg::POS_W-1:0]  player_y_q;
	logic [grmc_pkg::STEP_W-1:0] step_q;
	logic [grmc_pkg::MAXD_W-1:0] maxd_q;
	logic [grmc_pkg::BIAS_W-1:0] bias_q;
	logic [grmc_pkg::SCR_W-1:0]  scr_q;
	logic [grmc_pkg::MSZ_W-1:0]  map_w_q;
	logic [grmc_pkg::MSZ_W-1:0]  map_h_q;

	// Sequencer and march datapath
	logic [2:0]                   state_q;
	logic signed [31:0]           acc_x_q;
	logic signed [31:0]           acc_y_q;
	logic signed [24:0]           inc_x_q;
	logic signed [24:0]           inc_y_q;
	logic [grmc_pkg::DIST_W-1:0]  d_q;
	logic                         hit_q;
	logic [grmc_pkg::COL_W-1:0]   column_q;

	// Output register
	logic                          out_valid_q;
	logic [grmc_pkg::COL_W-1:0]    o_column_q;
	logic [grmc_pkg::DIST_W-1:0]   o_dist_q;
	logic                          o_hit_q;
	logic [grmc_pkg::SCR_W-1:0]    o_top_q;
	logic [grmc_pkg::SCR_W-1:0]    o_bot_q;
	logic [grmc_pkg::SHADE_W-1:0]  o_shade_q;

	logic                          clearing;
	logic                          in_xfer;
	logic                          cast_xfer;
	logic                          map_wr_en;
	logic [AW-1:0]                 map_wr_addr;
	logic                          map_rd_en;
	logic [AW-1:0]                 map_rd_addr;
	logic                          map_rd_data;
	logic [grmc_pkg::STEP_W:0]     step_eff;
	cell_t                         cx;
	cell_t                         cy;
	logic                          range_done;
	logic                          off_map;
	logic [grmc_pkg::DIV_DEN_W-1:0] den_sum;
	logic [grmc_pkg::DIV_DEN_W-1:0] den;
	logic                          div_start;
	logic                          div_busy;
	logic [grmc_pkg::DIV_NUM_W-1:0] quo;
	logic                          out_load;
	logic [grmc_pkg::DIV_NUM_W-1:0] half;
	logic [grmc_pkg::DIV_NUM_W-1:0] hh;
	logic [grmc_pkg::DIV_NUM_W-1:0] bot_sum;
	logic [grmc_pkg::SCR_W-1:0]    top_val;
	logic [grmc_pkg::SCR_W-1:0]    bot_val;
	logic [17:0]                   shade_sub;
	logic [17:0]                   shade_diff;
	logic [grmc_pkg::SHADE_W-1:0]  shade_val;

	// Truncate a Q.22 coordinate toward zero; flag a negative cell
	function automatic cell_t cell_of(input logic signed [31:0] a);
		cell_t c;
		c.neg_out = a[31] && !((&a[31:22]) && (|a[21:0]));
		c.idx     = a[31] ? 9'd0 : a[30:22];
		return c;
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= grmc_pkg::RST_PLAYER_X;
			player_y_q <= grmc_pkg::RST_PLAYER_Y;
			step_q     <= grmc_pkg::RST_STEP_SIZE;
			maxd_q     <= grmc_pkg::RST_MAX_DISTANCE;
			bias_q     <= grmc_pkg::RST_NEAR_BIAS;
			scr_q      <= grmc_pkg::RST_SCREEN_HEIGHT;
			map_w_q    <= grmc_pkg::RST_MAP_WIDTH;
			map_h_q    <= grmc_pkg::RST_MAP_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grmc_pkg::CFG_PLAYER_X:      player_x_q <= cfg_data[grmc_pkg::POS_W-1:0];
				grmc_pkg::CFG_PLAYER_Y:      player_y_q <= cfg_data[grmc_pkg::POS_W-1:0];
				grmc_pkg::CFG_STEP_SIZE:     step_q     <= cfg_data[grmc_pkg::STEP_W-1:0];
				grmc_pkg::CFG_MAX_DISTANCE:  maxd_q     <= cfg_data[grmc_pkg::MAXD_W-1:0];
				grmc_pkg::CFG_NEAR_BIAS:     bias_q     <= cfg_data[grmc_pkg::BIAS_W-1:0];
				grmc_pkg::CFG_SCREEN_HEIGHT: scr_q      <= cfg_data[grmc_pkg::SCR_W-1:0];
				grmc_pkg::CFG_MAP_WIDTH:     map_w_q    <= cfg_data[grmc_pkg::MSZ_W-1:0];
				grmc_pkg::CFG_MAP_HEIGHT:    map_h_q    <= cfg_data[grmc_pkg::MSZ_W-1:0];
				default:                     ;
			endcase
		end
	end

	// Input handshake and map write
	assign req.ready  = (state_q == ST_IDLE) && !clearing;
	assign in_xfer    = req.valid && req.ready;
	assign cast_xfer  = in_xfer && (req.action == grmc_pkg::ACT_CAST);
	assign map_wr_en  = in_xfer && (req.action == grmc_pkg::ACT_WRITE)
		&& (int'(req.cell_row) < MAP_DIM) && (int'(req.cell_col) < MAP_DIM);
	assign map_wr_addr = AW'(req.cell_row) * AW'(MAP_DIM) + AW'(req.cell_col);
	assign step_eff   = (step_q == '0) ? 9'd1 : {1'b0, step_q};

	// Cell test for the current march point
	always_comb begin
		cx         = cell_of(acc_x_q);
		cy         = cell_of(acc_y_q);
		range_done = d_q >= grmc_pkg::DIST_W'(maxd_q);
		off_map    = cx.neg_out || cy.neg_out
			|| (cx.idx >= 9'(map_w_q)) || (cy.idx >= 9'(map_h_q))
			|| (int'(cx.idx) >= MAP_DIM) || (int'(cy.idx) >= MAP_DIM);
	end

	assign map_rd_en   = (state_q == ST_CHECK) && !range_done && !off_map;
	assign map_rd_addr = AW'(cx.idx) * AW'(MAP_DIM) + AW'(cy.idx);

	grmc_map #(
		.MAP_DIM (MAP_DIM)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (map_wr_en),
		.wr_addr  (map_wr_addr),
		.wr_data  (req.cell_wall),
		.rd_en    (map_rd_en),
		.rd_addr  (map_rd_addr),
		.rd_data  (map_rd_data),
		.clearing (clearing)
	);

	// Slice height divide
	assign den_sum   = grmc_pkg::DIV_DEN_W'(d_q) + grmc_pkg::DIV_DEN_W'(bias_q);
	assign den       = (den_sum == '0) ? grmc_pkg::DIV_DEN_W'(1) : den_sum;
	assign div_start = (state_q == ST_DIVGO);

	grmc_div #(
		.NUM_W (grmc_pkg::DIV_NUM_W),
		.DEN_W (grmc_pkg::DIV_DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({scr_q, 8'd0}),
		.den    (den),
		.busy   (div_busy),
		.quo    (quo)
	);

	// Slice rows and shade
	always_comb begin
		half    = grmc_pkg::DIV_NUM_W'(scr_q[grmc_pkg::SCR_W-1:1]);
		hh      = {1'b0, quo[grmc_pkg::DIV_NUM_W-1:1]};
		bot_sum = half + hh;
		top_val = (hh > half) ? '0 : grmc_pkg::SCR_W'(half - hh);
		if (bot_sum >= grmc_pkg::DIV_NUM_W'(scr_q)) begin
			bot_val = (scr_q == '0) ? '0 : scr_q - grmc_pkg::SCR_W'(1);
		end else begin
			bot_val = grmc_pkg::SCR_W'(bot_sum);
		end
		shade_sub  = (18'(d_q) << 4) - 18'(d_q);
		shade_diff = 18'(grmc_pkg::SHADE_FULL) - shade_sub;
		shade_val  = (shade_sub >= 18'(grmc_pkg::SHADE_FULL)) ? '0 : shade_diff[15:8];
	end

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (cast_xfer) state_q <= ST_CHECK;
				ST_CHECK: begin
					if (range_done || off_map) begin
						state_q <= ST_DIVGO;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ:  state_q <= map_rd_data ? ST_DIVGO : ST_CHECK;
				ST_DIVGO: state_q <= ST_DIVW;
				ST_DIVW:  if (!div_busy) state_q <= ST_FIN;
				ST_FIN:   if (out_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// March datapath
	always_ff @(posedge clk) begin
		if (cast_xfer) begin
			acc_x_q  <= $signed({2'b00, player_x_q, 14'd0});
			acc_y_q  <= $signed({2'b00, player_y_q, 14'd0});
			inc_x_q  <= req.ray_dx * $signed(step_eff);
			inc_y_q  <= req.ray_dy * $signed(step_eff);
			d_q      <= '0;
			hit_q    <= 1'b0;
			column_q <= req.column;
		end else if (state_q == ST_CHECK) begin
			if (!range_done && off_map) begin
				d_q <= grmc_pkg::DIST_W'(maxd_q);
			end
		end else if (state_q == ST_READ) begin
			if (map_rd_data) begin
				hit_q <= 1'b1;
			end else begin
				acc_x_q <= acc_x_q + 32'(inc_x_q);
				acc_y_q <= acc_y_q + 32'(inc_y_q);
				d_q     <= d_q + grmc_pkg::DIST_W'(step_eff);
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_column_q <= column_q;
			o_dist_q   <= d_q;
			o_hit_q    <= hit_q;
			o_top_q    <= top_val;
			o_bot_q    <= bot_val;
			o_shade_q  <= shade_val;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_column   = o_column_q;
	assign rsp.hit_distance = o_dist_q;
	assign rsp.wall_hit     = o_hit_q;
	assign rsp.slice_top    = o_top_q;
	assign rsp.slice_bottom = o_bot_q;
	assign rsp.shade        = o_shade_q;

endmodule

// ===== tb/grid_ray_march_column_core_tb.sv =====
`timescale 1ns / 100ps

module grid_ray_march_column_core_tb;
	import grmc_pkg::*;

	localparam int LONG_HOLD   = 2000;
	localparam int SETTLE      = 64;
	localparam int PHASES      = 15;
	localparam int PHASE_ITEMS = 125;
	localparam int HOLD_CASTS  = 8;
	localparam int MAX_SHOWN   = 100;
	localparam int DRAIN_LIMIT = 200000;
	localparam int RUN_LIMIT   = 80000000;

	typedef struct {
		logic                    action;
		logic [ROW_W-1:0]        cell_row;
		logic [ROW_W-1:0]        cell_col;
		logic                    cell_wall;
		logic [COL_W-1:0]        column;
		logic signed [DIR_W-1:0] ray_dx;
		logic signed [DIR_W-1:0] ray_dy;
	} ray_item_t;

	typedef struct {
		logic [COL_W-1:0]   out_column;
		logic [DIST_W-1:0]  hit_distance;
		logic               wall_hit;
		logic [SCR_W-1:0]   slice_top;
		logic [SCR_W-1:0]   slice_bottom;
		logic [SHADE_W-1:0] shade;
	} column_t;

	typedef struct {
		logic [POS_W-1:0]  player_x;
		logic [POS_W-1:0]  player_y;
		logic [STEP_W-1:0] step_size;
		logic [MAXD_W-1:0] max_distance;
		logic [BIAS_W-1:0] near_bias;
		logic [SCR_W-1:0]  scr_rows;
		logic [MSZ_W-1:0]  grid_w;
		logic [MSZ_W-1:0]  grid_h;
	} view_t;

	typedef enum logic [1:0] {ROW_REG, ROW_ITEM, ROW_KNOWN} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		ray_item_t             item;
		column_t               known;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	grmc_req_if ray_req ();
	grmc_rsp_if ray_rsp ();

	// predictor state: register copy and wall map copy
	view_t       view;
	bit          wall_map [MAP_DIM][MAP_DIM];
	column_t     pending_columns [$];
	script_row_t script [$];
	int          mismatches;
	bit          no_gaps;
	bit          rsp_hold_req;

	grid_ray_march_column_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (ray_req),
		.rsp       (ray_rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("grid_ray_march_column_core_tb failed");
		$finish;
	end

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// truncate a Q.22 value toward zero
	function automatic longint trunc_q22(longint v);
		return (v < 0) ? -((-v) >>> 22) : (v >>> 22);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_PLAYER_X:      view.player_x     = val[POS_W-1:0];
			CFG_PLAYER_Y:      view.player_y     = val[POS_W-1:0];
			CFG_STEP_SIZE:     view.step_size    = val[STEP_W-1:0];
			CFG_MAX_DISTANCE:  view.max_distance = val[MAXD_W-1:0];
			CFG_NEAR_BIAS:     view.near_bias    = val[BIAS_W-1:0];
			CFG_SCREEN_HEIGHT: view.scr_rows     = val[SCR_W-1:0];
			CFG_MAP_WIDTH:     view.grid_w       = val[MSZ_W-1:0];
			CFG_MAP_HEIGHT:    view.grid_h       = val[MSZ_W-1:0];
			default: ;
		endcase
	endfunction

	// march one ray through the wall map and build the column it draws
	function automatic column_t march_column(ray_item_t it);
		column_t res;
		longint  dx, dy, cx, cy;
		int      stride, march_d, limit, mw, mh, den, rows, height, half, top, bot, level;
		bit      hit;
		dx      = longint'(it.ray_dx);
		dy      = longint'(it.ray_dy);
		stride  = (view.step_size == 0) ? 1 : int'(view.step_size);
		limit   = int'(view.max_distance);
		mw      = int'(view.grid_w);
		mh      = int'(view.grid_h);
		rows    = int'(view.scr_rows);
		march_d = 0;
		hit     = 1'b0;
		while (march_d < limit) begin
			cx = trunc_q22((longint'(view.player_x) <<< 14) + dx * march_d);
			cy = trunc_q22((longint'(view.player_y) <<< 14) + dy * march_d);
			if (cx < 0 || cy < 0 || cx >= mw || cy >= mh || cx >= MAP_DIM || cy >= MAP_DIM) begin
				march_d = limit;
				break;
			end
			if (wall_map[cx][cy]) begin
				hit = 1'b1;
				break;
			end
			march_d += stride;
		end

		// slice rows from height / (distance + bias), clamped to the screen
		den = march_d + int'(view.near_bias);
		if (den == 0)
			den = 1;
		height = (rows * 256) / den;
		half   = rows / 2;
		top    = half - height / 2;
		if (top < 0)
			top = 0;
		bot = half + height / 2;
		if (bot >= rows)
			bot = (rows != 0) ? rows - 1 : 0;
		level = SHADE_FULL - 15 * march_d;

		res.out_column   = it.column;
		res.hit_distance = march_d[DIST_W-1:0];
		res.wall_hit     = hit;
		res.slice_top    = top[SCR_W-1:0];
		res.slice_bottom = bot[SCR_W-1:0];
		res.shade        = (level <= 0) ? '0 : level[15:8];
		return res;
	endfunction

	// directed rows
	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int val);
		script_row_t r;
		r.kind      = ROW_REG;
		r.reg_index = idx;
		r.reg_value = val[CFG_DATA_W-1:0];
		script.push_back(r);
	endfunction

	function automatic void add_cell(int row, int col, bit wall);
		script_row_t r;
		r.kind      = ROW_ITEM;
		r.reg_index = CFG_PLAYER_X;
		r.reg_value = '0;
		r.item      = '{ACT_WRITE, row[ROW_W-1:0], col[ROW_W-1:0], wall, '0, '0, '0};
		script.push_back(r);
	endfunction

	function automatic void add_cast(int col, int dx, int dy);
		script_row_t r;
		r.kind      = ROW_ITEM;
		r.reg_index = CFG_PLAYER_X;
		r.reg_value = '0;
		r.item      = '{ACT_CAST, '0, '0, 1'b0, col[COL_W-1:0], dx[DIR_W-1:0], dy[DIR_W-1:0]};
		script.push_back(r);
	endfunction

	function automatic void add_known(int col, int dx, int dy, int dist_q8, bit hit,
			int top, int bot, int shade);
		add_cast(col, dx, dy);
		script[$].kind  = ROW_KNOWN;
		script[$].known = '{col[COL_W-1:0], dist_q8[DIST_W-1:0], hit, top[SCR_W-1:0],
			bot[SCR_W-1:0], shade[SHADE_W-1:0]};
	endfunction

	function automatic ray_item_t random_item(bit cast_only);
		ray_item_t it;
		int        dx, dy;
		it.action    = (cast_only || $urandom_range(0, 99) >= 35) ? ACT_CAST : ACT_WRITE;
		it.cell_row  = ROW_W'($urandom_range(0, 31));
		it.cell_col  = ROW_W'($urandom_range(0, 31));
		it.cell_wall = ($urandom_range(0, 99) < 40);
		it.column    = COL_W'($urandom_range(0, 4095));
		case ($urandom_range(0, 7))
			0: begin
				dx = 0;
				dy = 0;
			end
			1: begin
				dx = $urandom_range(0, 1) ? 16384 : -16384;
				dy = 0;
			end
			2: begin
				dx = 0;
				dy = $urandom_range(0, 1) ? 16384 : -16384;
			end
			default: begin
				dx = int'($urandom_range(0, 32768)) - 16384;
				dy = int'($urandom_range(0, 32768)) - 16384;
			end
		endcase
		it.ray_dx = dx[DIR_W-1:0];
		it.ray_dy = dy[DIR_W-1:0];
		return it;
	endfunction

	function automatic int pick_extent();
		case ($urandom_range(0, 9))
			0: return 1;
			1: return $urandom_range(33, 63);
			2: return MAP_DIM;
			default: return $urandom_range(4, MAP_DIM);
		endcase
	endfunction

	// mostly inside the map, sometimes anywhere
	function automatic int pick_spot(int extent);
		int cells;
		cells = (extent < MAP_DIM) ? extent : MAP_DIM;
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 65535);
		return $urandom_range(0, cells - 1) * 256 + $urandom_range(0, 255);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		apply_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one transfer on the request side, then predict
	task automatic offer(ray_item_t it, bit use_known, column_t known);
		ray_req.valid     <= 1'b1;
		ray_req.action    <= it.action;
		ray_req.cell_row  <= it.cell_row;
		ray_req.cell_col  <= it.cell_col;
		ray_req.cell_wall <= it.cell_wall;
		ray_req.column    <= it.column;
		ray_req.ray_dx    <= it.ray_dx;
		ray_req.ray_dy    <= it.ray_dy;
		do @(posedge clk); while (!ray_req.ready);
		if (it.action == ACT_WRITE)
			wall_map[it.cell_row][it.cell_col] = it.cell_wall;
		else
			pending_columns.push_back(use_known ? known : march_column(it));
	endtask

	task automatic maybe_gap();
		if (!no_gaps && $urandom_range(0, 5) == 0) begin
			ray_req.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// wait for every cast to come back, then let a trailing map write settle
	task automatic drain(int settle);
		ray_req.valid <= 1'b0;
		do @(posedge clk); while (pending_columns.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic pick_view();
		int mw, mh, stride, cap, maxd, bias, rows;
		mw = pick_extent();
		mh = pick_extent();
		case ($urandom_range(0, 7))
			0: stride = 0;
			1: stride = 1;
			2: stride = 255;
			default: stride = $urandom_range(8, 255);
		endcase
		// keep a march under about 250 steps
		cap = ((stride == 0) ? 1 : stride) * 250;
		if (cap > 8191)
			cap = 8191;
		case ($urandom_range(0, 7))
			0: maxd = 0;
			1: maxd = cap;
			default: maxd = $urandom_range(1, cap);
		endcase
		case ($urandom_range(0, 7))
			0: bias = 0;
			1: bias = 255;
			default: bias = $urandom_range(1, 254);
		endcase
		case ($urandom_range(0, 7))
			0: rows = 0;
			1: rows = 2;
			2: rows = 4095;
			default: rows = $urandom_range(2, 4095);
		endcase
		write_reg(CFG_MAP_WIDTH, CFG_DATA_W'(mw));
		write_reg(CFG_MAP_HEIGHT, CFG_DATA_W'(mh));
		write_reg(CFG_PLAYER_X, CFG_DATA_W'(pick_spot(mw)));
		write_reg(CFG_PLAYER_Y, CFG_DATA_W'(pick_spot(mh)));
		write_reg(CFG_STEP_SIZE, CFG_DATA_W'(stride));
		write_reg(CFG_MAX_DISTANCE, CFG_DATA_W'(maxd));
		write_reg(CFG_NEAR_BIAS, CFG_DATA_W'(bias));
		write_reg(CFG_SCREEN_HEIGHT, CFG_DATA_W'(rows));
	endtask

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		ray_rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_req) begin
				stall_left   = LONG_HOLD;
				rsp_hold_req = 1'b0;
			end else if (stall_left == 0 && !no_gaps && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 13);
			if (stall_left > 0) begin
				ray_rsp.ready <= 1'b0;
				stall_left--;
			end else
				ray_rsp.ready <= 1'b1;
		end
	end

	// compare each result transfer with the oldest pending column
	always @(posedge clk) begin : check_result
		column_t want;
		if (arst_n && ray_rsp.valid && ray_rsp.ready) begin
			if (pending_columns.size() == 0)
				report_mismatch("result with no cast pending");
			else begin
				want = pending_columns.pop_front();
				check_field("out_column", 16'(ray_rsp.out_column), 16'(want.out_column));
				check_field("hit_distance", 16'(ray_rsp.hit_distance),
					16'(want.hit_distance));
				check_field("wall_hit", 16'(ray_rsp.wall_hit), 16'(want.wall_hit));
				check_field("slice_top", 16'(ray_rsp.slice_top), 16'(want.slice_top));
				check_field("slice_bottom", 16'(ray_rsp.slice_bottom),
					16'(want.slice_bottom));
				check_field("shade", 16'(ray_rsp.shade), 16'(want.shade));
			end
		end
	end

	initial begin : stimulus
		column_t unknown;
		bit      prev_item;
		int      phase, k, first;

		unknown      = '{default: '0};
		mismatches   = 0;
		no_gaps      = 1'b0;
		rsp_hold_req = 1'b0;
		view.player_x     = RST_PLAYER_X;
		view.player_y     = RST_PLAYER_Y;
		view.step_size    = RST_STEP_SIZE;
		view.max_distance = RST_MAX_DISTANCE;
		view.near_bias    = RST_NEAR_BIAS;
		view.scr_rows     = RST_SCREEN_HEIGHT;
		view.grid_w       = RST_MAP_WIDTH;
		view.grid_h       = RST_MAP_HEIGHT;

		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= CFG_PLAYER_X;
		cfg_data          <= '0;
		ray_req.valid     <= 1'b0;
		ray_req.action    <= ACT_WRITE;
		ray_req.cell_row  <= '0;
		ray_req.cell_col  <= '0;
		ray_req.cell_wall <= 1'b0;
		ray_req.column    <= '0;
		ray_req.ray_dx    <= '0;
		ray_req.ray_dy    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: player at (3,3), empty map, range exhausted
		add_known(0, 0, 0, 4108, 1'b0, 470, 530, 14);
		// wall on the player cell stops the march at once
		add_cell(3, 3, 1'b1);
		add_known(4095, 16384, -16384, 0, 1'b1, 0, 999, 255);
		add_cell(3, 3, 1'b0);
		add_cell(7, 3, 1'b1);
		add_cell(0, 0, 1'b1);
		add_cell(31, 31, 1'b1);
		add_cast(100, 16384, 0);
		// leaving through negative x
		add_known(200, -16384, 0, 4096, 1'b0, 469, 531, 15);
		add_cast(300, 11585, 11585);
		add_cast(301, -9000, -13000);
		// leaving through the far edge at the longest range
		add_reg(CFG_MAX_DISTANCE, 8191);
		add_reg(CFG_STEP_SIZE, 255);
		add_known(400, 0, 16384, 8191, 1'b0, 485, 515, 0);
		// zero step counts as one
		add_reg(CFG_STEP_SIZE, 0);
		add_reg(CFG_MAX_DISTANCE, 40);
		add_known(500, 0, 0, 40, 1'b0, 0, 999, 252);
		// zero range and zero divisor
		add_reg(CFG_MAX_DISTANCE, 0);
		add_reg(CFG_NEAR_BIAS, 0);
		add_known(600, -16384, 16384, 0, 1'b0, 0, 999, 255);
		add_reg(CFG_SCREEN_HEIGHT, 0);
		add_known(700, 0, 0, 0, 1'b0, 0, 0, 255);
		// largest screen, bias, step and range
		add_reg(CFG_SCREEN_HEIGHT, 4095);
		add_reg(CFG_MAX_DISTANCE, 8191);
		add_reg(CFG_NEAR_BIAS, 255);
		add_reg(CFG_STEP_SIZE, 255);
		add_known(800, 0, 0, 8415, 1'b0, 1987, 2107, 0);
		add_reg(CFG_PLAYER_X, 65535);
		add_reg(CFG_PLAYER_Y, 0);
		add_known(900, 16384, 16384, 8191, 1'b0, 1985, 2109, 0);
		// map wider than the store: cells past the store are outside
		add_reg(CFG_MAP_WIDTH, 63);
		add_reg(CFG_MAP_HEIGHT, 63);
		add_reg(CFG_PLAYER_X, 31 * 256 + 128);
		add_reg(CFG_PLAYER_Y, 31 * 256 + 128);
		add_known(1000, 0, 0, 0, 1'b1, 0, 4094, 255);
		add_cell(31, 31, 1'b0);
		add_cast(1001, 16384, -4000);
		add_cast(1002, -16384, -16384);
		// smallest map
		add_reg(CFG_MAP_WIDTH, 1);
		add_reg(CFG_MAP_HEIGHT, 1);
		add_reg(CFG_PLAYER_X, 128);
		add_reg(CFG_PLAYER_Y, 128);
		add_cell(0, 0, 1'b0);
		add_cast(1003, 3000, -3000);

		prev_item = 1'b1;
		foreach (script[i]) begin
			if (script[i].kind == ROW_REG) begin
				if (prev_item)
					drain(SETTLE);
				write_reg(script[i].reg_index, script[i].reg_value);
				prev_item = 1'b0;
			end else begin
				offer(script[i].item, script[i].kind == ROW_KNOWN, script[i].known);
				maybe_gap();
				prev_item = 1'b1;
			end
		end

		// random phases, each under a fresh setting
		for (phase = 0; phase < PHASES; phase++) begin
			drain(SETTLE);
			no_gaps = (phase >= PHASES - 2) || ($urandom_range(0, 3) == 0);
			pick_view();
			first = 0;
			if (phase == 1) begin
				// long receiver hold while casts keep coming
				rsp_hold_req = 1'b1;
				for (k = 0; k < HOLD_CASTS; k++)
					offer(random_item(1'b1), 1'b0, unknown);
				first = HOLD_CASTS;
			end
			for (k = first; k < PHASE_ITEMS; k++) begin
				if (phase == 4 && k == PHASE_ITEMS / 2)
					drain(0);
				offer(random_item(1'b0), 1'b0, unknown);
				maybe_gap();
			end
		end

		// wind down
		ray_req.valid <= 1'b0;
		for (k = 0; k < DRAIN_LIMIT && pending_columns.size() != 0; k++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (pending_columns.size() != 0)
			report_mismatch($sformatf("%0d casts never answered", pending_columns.size()));

		if (mismatches == 0)
			$display("grid_ray_march_column_core_tb passed");
		else
			$display("grid_ray_march_column_core_tb failed");
		$finish;
	end

endmodule
